### rtl/core/sha256_pkg.sv
// SHA-256 hasher package: controller command/status types, state enum,
// round constants and the SHA-256 helper functions. No dependencies.
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic take_byte;   // place input byte, bump count and length
        logic pad;         // write 0x80 and clear the tail of the block
        logic clear_block; // zero all block words (extra padding block)
        logic put_length;  // write bit length into words 14 and 15
        logic start;       // load working words from hash words
        logic round;       // run one compression round
        logic add;         // fold working words into hash words
        logic shift_out;   // advance digest output word
        logic restart;     // reset hash, count and length
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic block_full;  // count wraps on this byte
        logic pad_extra;   // 56 or more bytes pending at pad time
        logic last_round;  // round counter at 63
    } t_stat;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_LIMIT = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

### rtl/core/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher top level: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
//
//  channel | signals                                         | dir
//  in      | i_in_valid/o_in_ready, message_byte, byte_present, end_of_message | in
//  out     | o_out_valid/i_out_ready, digest_word, word_number, last_word     | out
//
// A byte that does not fill a block is only stored. The 64th byte of a block
// is accepted and loads the working words, then one round per cycle runs on
// the single round unit, then the add. An end mark is accepted, then pad and
// load, 64 rounds and add, again load, rounds and add for an extra padding
// block when needed, then eight digest words. Reset is synchronous and clears
// control, counters and hash words; output stalls simply hold the current word.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_last_word
);

    sha256_pkg::t_cmd  w_cmd;
    sha256_pkg::t_stat w_stat;

    sha256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_last_out       (o_last_word),
        .i_stat           (w_stat),
        .o_cmd            (w_cmd)
    );

    sha256_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_message_byte (i_message_byte),
        .o_stat         (w_stat),
        .o_digest_word  (o_digest_word),
        .o_word_number  (o_word_number),
        .o_last_word    (o_last_word)
    );

    // never take input while digest words are being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output active together");

    // after the last word is taken the block goes back to accepting input
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word) |=> (o_in_ready && !o_out_valid))
        else $error("not idle after last digest word");

    // word number advances by one on each taken word within a digest
    a_word_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_word)
            |=> (o_word_number == $past(o_word_number) + 3'd1))
        else $error("digest word order broken");

endmodule

### rtl/core/sha256_ctrl.sv
// SHA-256 hasher controller: sequences byte intake, padding, the 64 rounds
// and the digest output. Depends on sha256_pkg.
module sha256_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_byte_present,
    input  logic               i_end_of_message,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic               i_last_out,
    input  sha256_pkg::t_stat  i_stat,
    output sha256_pkg::t_cmd   o_cmd
);

    sha256_pkg::t_state r_state, n_state;
    // pending work after the current compression
    logic r_fin, n_fin;      // message closing, pad still to do
    logic r_len, n_len;      // length block still to compress
    logic r_emit, n_emit;    // after compression, emit digest

    logic w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_fin = r_fin;
        n_len = r_len;
        n_emit = r_emit;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_fin = i_end_of_message;
                    n_len = 1'b0;
                    n_emit = 1'b0;
                    if (i_byte_present && i_stat.block_full) begin
                        n_state = sha256_pkg::ST_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                n_fin = 1'b0;
                n_state = sha256_pkg::ST_ROUND;
                if (i_stat.pad_extra) begin
                    n_len = 1'b1;
                end else begin
                    n_emit = 1'b1;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (i_stat.last_round) n_state = sha256_pkg::ST_ADD;
            end
            sha256_pkg::ST_ADD: begin
                if (r_fin) begin
                    n_state = sha256_pkg::ST_PAD;
                end else if (r_len) begin
                    n_len = 1'b0;
                    n_emit = 1'b1;
                    n_state = sha256_pkg::ST_ROUND;
                end else if (r_emit) begin
                    n_state = sha256_pkg::ST_EMIT;
                end else begin
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_EMIT: begin
                if (i_out_ready && i_last_out) begin
                    n_emit = 1'b0;
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take_byte = w_acc && i_byte_present;
                o_cmd.start = w_acc && i_byte_present && i_stat.block_full;
            end
            sha256_pkg::ST_PAD: begin
                o_cmd.pad = 1'b1;
                o_cmd.put_length = !i_stat.pad_extra;
                o_cmd.start = 1'b1;
            end
            sha256_pkg::ST_ROUND: o_cmd.round = 1'b1;
            sha256_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
                // length block follows: load its working words in the same cycle
                o_cmd.start = r_len;
                o_cmd.clear_block = r_len;
                o_cmd.put_length = r_len;
            end
            sha256_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.shift_out = i_out_ready;
                o_cmd.restart = i_out_ready && i_last_out;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::ST_IDLE;
            r_fin <= 1'b0;
            r_len <= 1'b0;
            r_emit <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin <= n_fin;
            r_len <= n_len;
            r_emit <= n_emit;
        end
    end

endmodule

### rtl/core/sha256_dp.sv
// SHA-256 hasher datapath: block words, message schedule window, working
// words, hash words, counters and digest output. Depends on sha256_pkg.
module sha256_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha256_pkg::t_cmd   i_cmd,
    input  logic [7:0]         i_message_byte,
    output sha256_pkg::t_stat  o_stat,
    output logic [31:0]        o_digest_word,
    output logic [2:0]         o_word_number,
    output logic               o_last_word
);

    logic [31:0] r_blk [16];     // block words, also the schedule window
    logic [31:0] n_blk [16];
    logic [31:0] r_wk  [8];
    logic [31:0] r_hash [8];
    logic [5:0]  r_cnt;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic [2:0]  r_outw;

    logic [3:0]  w_widx;
    logic [1:0]  w_bidx;
    logic [31:0] w_t1, w_t2, w_wnext;

    assign o_stat.block_full = (r_cnt == 6'd63);
    assign o_stat.pad_extra  = (r_cnt >= sha256_pkg::LEN_LIMIT);
    assign o_stat.last_round = (r_rnd == 6'd63);

    assign w_widx = r_cnt[5:2];
    assign w_bidx = r_cnt[1:0];

    // round logic; r_blk[0] holds the schedule word of this round
    assign w_t1 = r_wk[7] + sha256_pkg::bsig1(r_wk[4])
                + ((r_wk[4] & r_wk[5]) ^ (~r_wk[4] & r_wk[6]))
                + sha256_pkg::ROUND_K[r_rnd] + r_blk[0];
    assign w_t2 = sha256_pkg::bsig0(r_wk[0])
                + ((r_wk[0] & r_wk[1]) ^ (r_wk[0] & r_wk[2]) ^ (r_wk[1] & r_wk[2]));
    assign w_wnext = r_blk[0] + sha256_pkg::sig0(r_blk[1]) + r_blk[9]
                   + sha256_pkg::sig1(r_blk[14]);

    // block word updates
    always_comb begin
        for (int i = 0; i < 16; i++) n_blk[i] = r_blk[i];
        if (i_cmd.take_byte) begin
            if (w_bidx == 2'd0) n_blk[w_widx] = '0;
            n_blk[w_widx][(5'd3 - {3'd0, w_bidx}) * 8 +: 8] = i_message_byte;
        end
        if (i_cmd.pad) begin
            if (w_bidx == 2'd0) n_blk[w_widx] = '0;
            n_blk[w_widx][(5'd3 - {3'd0, w_bidx}) * 8 +: 8] = sha256_pkg::PAD_BYTE;
            for (int i = 0; i < 16; i++) begin
                if (4'(i) > w_widx) n_blk[i] = '0;
            end
        end
        if (i_cmd.clear_block) begin
            for (int i = 0; i < 16; i++) n_blk[i] = '0;
        end
        if (i_cmd.put_length) begin
            n_blk[14] = r_len[63:32];
            n_blk[15] = r_len[31:0];
        end
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) n_blk[i] = r_blk[i + 1];
            n_blk[15] = w_wnext;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) r_blk[i] <= n_blk[i];
        if (i_cmd.start) begin
            // with add, the next block starts from the freshly folded hash
            for (int i = 0; i < 8; i++) begin
                r_wk[i] <= i_cmd.add ? (r_hash[i] + r_wk[i]) : r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_wk[0] <= w_t1 + w_t2;
            r_wk[1] <= r_wk[0];
            r_wk[2] <= r_wk[1];
            r_wk[3] <= r_wk[2];
            r_wk[4] <= r_wk[3] + w_t1;
            r_wk[5] <= r_wk[4];
            r_wk[6] <= r_wk[5];
            r_wk[7] <= r_wk[6];
        end
    end

    // hash, counters, output pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) r_hash[i] <= sha256_pkg::INIT_HASH[i];
            r_cnt <= '0;
            r_len <= '0;
            r_rnd <= '0;
            r_outw <= '0;
        end else begin
            if (i_cmd.add) begin
                for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_wk[i];
            end
            if (i_cmd.take_byte) begin
                r_cnt <= r_cnt + 6'd1;
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.pad) r_cnt <= '0;
            if (i_cmd.round) r_rnd <= r_rnd + 6'd1;
            if (i_cmd.shift_out) r_outw <= r_outw + 3'd1;
        end
    end

    assign o_digest_word = r_hash[r_outw];
    assign o_word_number = r_outw;
    assign o_last_word   = (r_outw == 3'd7);

endmodule
